// File: rtl/mstt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mstt_pkg;

  localparam int SLOTS          = 16;
  localparam int RESERVED_SLOTS = 0;
  localparam int MAX_RESULTS    = 16;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam int OP_W     = 3;
  localparam int OWNER_W  = 16;
  localparam int ID_W     = 15;
  localparam int TIME_W   = 24;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_SET      = 3'd1;
  localparam logic [OP_W-1:0] OP_KILL     = 3'd2;
  localparam logic [OP_W-1:0] OP_KILL_ALL = 3'd3;
  localparam logic [OP_W-1:0] OP_ENABLE   = 3'd4;
  localparam logic [OP_W-1:0] OP_DISABLE  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [OWNER_W-1:0] owner;
    logic [ID_W-1:0]    timer_id;
    logic [TIME_W-1:0]  period;
    logic [TIME_W-1:0]  elapsed;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic                fired;
    logic [OWNER_W-1:0]  fired_owner;
    logic [ID_W-1:0]     fired_timer_id;
    logic [TIME_W-1:0]   next_due;
    logic                last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic             start;   // capture input item
    logic             scan;    // per-slot operation pass
    logic             commit;  // finish set, latch status
    logic             min;     // next-due pass
    logic             load;    // load output register
    logic [IDX_W-1:0] idx;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic multi;      // tick with fired slots to report
    logic fire_bit;   // slot at idx fired in this tick
    logic emit_last;  // next fired result is the final one
    logic out_space;  // output register can take a result
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/mstt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mstt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mstt_pkg::dp_stat_t stat,
  output mstt_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_COMMIT = 5'b00100,
    S_MIN    = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  localparam logic [mstt_pkg::IDX_W-1:0] IDX_LAST = mstt_pkg::IDX_W'(mstt_pkg::SLOTS - 1);

  state_t                      state_r, state_nxt;
  logic [mstt_pkg::IDX_W-1:0]  idx_r, idx_nxt;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cmd        = '0;
    cmd.idx    = idx_r;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (idx_r == IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = S_COMMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        idx_nxt    = '0;
        state_nxt  = S_MIN;
      end
      S_MIN: begin
        cmd.min = 1'b1;
        if (idx_r == IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (!stat.multi) begin
          if (stat.out_space) begin
            cmd.load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (stat.fire_bit) begin
          if (stat.out_space) begin
            cmd.load = 1'b1;
            if (stat.emit_last) begin
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mstt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mstt_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mstt_pkg::in_item_t   in_data,
  input  wire mstt_pkg::ctrl_cmd_t  cmd,
  output mstt_pkg::dp_stat_t        stat,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output mstt_pkg::out_item_t       out_data
);

  localparam int SLOTS = mstt_pkg::SLOTS;
  localparam int IDX_W = mstt_pkg::IDX_W;
  localparam int CNT_W = mstt_pkg::CNT_W;

  // slot table
  logic [mstt_pkg::OWNER_W-1:0] owner_mem_r [SLOTS];
  logic [mstt_pkg::ID_W-1:0]    id_mem_r    [SLOTS];
  logic [mstt_pkg::TIME_W-1:0]  ival_mem_r  [SLOTS];
  logic [mstt_pkg::TIME_W-1:0]  rem_mem_r   [SLOTS];
  logic [SLOTS-1:0]             en_r;

  // captured item
  logic [mstt_pkg::OP_W-1:0]    op_r;
  logic [mstt_pkg::OWNER_W-1:0] owner_r;
  logic [mstt_pkg::ID_W-1:0]    id_r;
  logic [mstt_pkg::TIME_W-1:0]  period_r;
  logic [mstt_pkg::TIME_W-1:0]  elapsed_r;

  // per-operation bookkeeping
  logic [SLOTS-1:0]             fire_vec_r;
  logic [CNT_W-1:0]             fire_cnt_r;
  logic [CNT_W-1:0]             emit_cnt_r;
  logic                         found_r;
  logic                         free_found_r;
  logic [IDX_W-1:0]             match_idx_r;
  logic [IDX_W-1:0]             free_idx_r;
  logic [IDX_W-1:0]             hit_idx_r;
  logic [mstt_pkg::TIME_W-1:0]  best_r;
  logic [mstt_pkg::STATUS_W-1:0] status_r;
  logic [mstt_pkg::SLOT_W-1:0]  slot_r;

  logic                         out_valid_r, out_valid_nxt;
  mstt_pkg::out_item_t          out_data_r;

  // slot at the scan index
  logic [mstt_pkg::OWNER_W-1:0] cur_owner;
  logic [mstt_pkg::ID_W-1:0]    cur_id;
  logic [mstt_pkg::TIME_W-1:0]  cur_ival;
  logic [mstt_pkg::TIME_W-1:0]  cur_rem;
  logic                         cur_occ, cur_live, cur_open, fire_now;
  logic                         match_id, match_own, param_bad;
  logic [IDX_W-1:0]             target;
  logic                         set_go;
  logic [mstt_pkg::STATUS_W-1:0] status_nxt;
  logic [mstt_pkg::SLOT_W-1:0]  slot_nxt;
  mstt_pkg::out_item_t          res;

  assign cur_owner = owner_mem_r[cmd.idx];
  assign cur_id    = id_mem_r[cmd.idx];
  assign cur_ival  = ival_mem_r[cmd.idx];
  assign cur_rem   = rem_mem_r[cmd.idx];
  assign cur_occ   = (cur_id != '0);
  assign cur_live  = cur_occ && en_r[cmd.idx];
  assign cur_open  = (32'(cmd.idx) >= mstt_pkg::RESERVED_SLOTS);
  assign fire_now  = (elapsed_r >= cur_rem);

  // lookup by id (reserved slots excluded), optionally also by owner
  assign match_id  = cur_open && (id_r != '0) && (cur_id == id_r);
  assign match_own = match_id && ((owner_r == '0) || (cur_owner == owner_r));
  assign param_bad = (id_r == '0) || (period_r == '0);

  // set lands in the first free slot; a freed match counts as free
  assign target = (free_found_r && (!found_r || (free_idx_r < match_idx_r)))
                  ? free_idx_r : match_idx_r;
  assign set_go = (op_r == mstt_pkg::OP_SET) && !param_bad && (found_r || free_found_r);

  always_comb begin
    status_nxt = mstt_pkg::ST_OK;
    slot_nxt   = '0;
    case (op_r)
      mstt_pkg::OP_TICK: begin
        status_nxt = mstt_pkg::ST_OK;
      end
      mstt_pkg::OP_SET: begin
        if (param_bad) begin
          status_nxt = mstt_pkg::ST_INVALID;
        end else if (found_r || free_found_r) begin
          slot_nxt = mstt_pkg::SLOT_W'(target);
        end else begin
          status_nxt = mstt_pkg::ST_NO_SLOT;
        end
      end
      mstt_pkg::OP_KILL, mstt_pkg::OP_ENABLE, mstt_pkg::OP_DISABLE: begin
        if (found_r) begin
          slot_nxt = mstt_pkg::SLOT_W'(hit_idx_r);
        end else begin
          status_nxt = mstt_pkg::ST_NOT_FOUND;
        end
      end
      mstt_pkg::OP_KILL_ALL: begin
        status_nxt = found_r ? mstt_pkg::ST_OK : mstt_pkg::ST_NOT_FOUND;
      end
      default: begin
        status_nxt = mstt_pkg::ST_INVALID;
      end
    endcase
  end

  // status back to the controller
  assign stat.multi     = (op_r == mstt_pkg::OP_TICK) && (fire_cnt_r != '0);
  assign stat.fire_bit  = fire_vec_r[cmd.idx];
  assign stat.emit_last = ((emit_cnt_r + CNT_W'(1)) == fire_cnt_r);
  assign stat.out_space = !out_valid_r || out_ready;

  always_comb begin
    res = '0;
    res.next_due = best_r;
    if (stat.multi) begin
      res.status         = mstt_pkg::ST_OK;
      res.slot_index     = mstt_pkg::SLOT_W'(cmd.idx);
      res.fired          = 1'b1;
      res.fired_owner    = cur_owner;
      res.fired_timer_id = cur_id;
      res.last           = stat.emit_last;
    end else begin
      res.status     = status_r;
      res.slot_index = slot_r;
      res.last       = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state and slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        id_mem_r[i] <= '0;
      end
      en_r         <= '0;
      fire_vec_r   <= '0;
      fire_cnt_r   <= '0;
      emit_cnt_r   <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.start) begin
        fire_vec_r   <= '0;
        fire_cnt_r   <= '0;
        emit_cnt_r   <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
      end
      if (cmd.scan) begin
        case (op_r)
          mstt_pkg::OP_TICK: begin
            if (cur_live && fire_now && (fire_cnt_r < CNT_W'(mstt_pkg::MAX_RESULTS))) begin
              fire_vec_r[cmd.idx] <= 1'b1;
              fire_cnt_r          <= fire_cnt_r + 1'b1;
            end
          end
          mstt_pkg::OP_SET: begin
            if (!param_bad) begin
              if (match_own && !found_r) begin
                found_r <= 1'b1;
              end
              if (cur_open && !cur_occ && !free_found_r) begin
                free_found_r <= 1'b1;
              end
            end
          end
          mstt_pkg::OP_KILL: begin
            if (match_own && !found_r) begin
              found_r           <= 1'b1;
              id_mem_r[cmd.idx] <= '0;
              en_r[cmd.idx]     <= 1'b0;
            end
          end
          mstt_pkg::OP_KILL_ALL: begin
            if (cur_occ && (cur_owner == owner_r)) begin
              found_r           <= 1'b1;
              id_mem_r[cmd.idx] <= '0;
              en_r[cmd.idx]     <= 1'b0;
            end
          end
          mstt_pkg::OP_ENABLE, mstt_pkg::OP_DISABLE: begin
            if (match_id && !found_r) begin
              found_r       <= 1'b1;
              en_r[cmd.idx] <= (op_r == mstt_pkg::OP_ENABLE);
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.commit && (op_r == mstt_pkg::OP_SET) && !param_bad) begin
        // matched slot is freed unless the new timer lands right there
        if (found_r && (target != match_idx_r)) begin
          id_mem_r[match_idx_r] <= '0;
          en_r[match_idx_r]     <= 1'b0;
        end
        if (set_go) begin
          id_mem_r[target] <= id_r;
          en_r[target]     <= 1'b1;
        end
      end
      if (cmd.load && stat.multi) begin
        emit_cnt_r <= emit_cnt_r + 1'b1;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r      <= in_data.operation;
      owner_r   <= in_data.owner;
      id_r      <= in_data.timer_id;
      period_r  <= in_data.period;
      elapsed_r <= in_data.elapsed;
      best_r    <= '0;
    end
    if (cmd.scan) begin
      case (op_r)
        mstt_pkg::OP_TICK: begin
          if (cur_live) begin
            rem_mem_r[cmd.idx] <= fire_now ? cur_ival : (cur_rem - elapsed_r);
          end
        end
        mstt_pkg::OP_SET: begin
          if (match_own && !found_r) begin
            match_idx_r <= cmd.idx;
          end
          if (cur_open && !cur_occ && !free_found_r) begin
            free_idx_r <= cmd.idx;
          end
        end
        mstt_pkg::OP_KILL: begin
          if (match_own && !found_r) begin
            hit_idx_r <= cmd.idx;
          end
        end
        mstt_pkg::OP_ENABLE, mstt_pkg::OP_DISABLE: begin
          if (match_id && !found_r) begin
            hit_idx_r <= cmd.idx;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      if (set_go) begin
        owner_mem_r[target] <= owner_r;
        ival_mem_r[target]  <= period_r;
        rem_mem_r[target]   <= period_r;
      end
    end
    if (cmd.min && cur_live && ((best_r == '0) || (cur_rem < best_r))) begin
      best_r <= cur_rem;
    end
    if (cmd.load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fire_cnt_r <= CNT_W'(mstt_pkg::MAX_RESULTS))
    else $error("fired count above result cap");

  a_fire_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(fire_vec_r) == 32'(fire_cnt_r))
    else $error("fired vector and count disagree");

  a_emit_fired: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && stat.multi) |-> (stat.fire_bit && stat.out_space))
    else $error("fired result loaded from a slot that did not fire");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_cnt_r <= fire_cnt_r)
    else $error("more fired results sent than recorded");

endmodule

`default_nettype wire

// File: rtl/multi_slot_periodic_timer_table.sv
// Periodic timer table with SLOTS slots (owner, id, enable, interval, remaining).
// Input channel in_valid/in_ready/in_data carries one operation per transfer:
// tick, set, kill, kill_all, enable or disable. Result channel
// out_valid/out_ready/out_data returns one result per non-tick operation, and
// for a tick one result per fired slot in slot order (or one idle result);
// the final result of an operation has last set, and every result carries the
// smallest remaining count of the enabled slots after the operation.
// Timing: one operation at a time. After the input transfer the slot table is
// walked once for the operation, then a commit step, and once more for
// next_due; the emit state then loads the first result. A tick's fired results
// walk the table again, one slot per cycle while the output register has space.
// A new operation is taken only once the last result is loaded, as the slot
// walk is single-ported. in_ready is high between operations even while the
// last result still waits in the output register.
// Reset (rst_n low at a clock edge) frees every slot and empties the output
// register. When the receiver stalls, a pending result holds in the output
// register and the walk pauses on the next fired slot until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_periodic_timer_table (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mstt_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mstt_pkg::out_item_t      out_data
);

  mstt_pkg::ctrl_cmd_t cmd;   // sequencer commands: phase strobes and slot index
  mstt_pkg::dp_stat_t  stat;  // datapath status back to the sequencer

  // sequencer: idle -> operation walk -> commit -> next-due walk -> emit
  mstt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot table, per-slot operation logic, next-due tracker, output register
  mstt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: sim/mstt_checker.sv
`timescale 1ns / 1ps

module mstt_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire mstt_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire mstt_pkg::out_item_t out_data,
  output int                       mismatches,
  output int                       results_owed
);

  // shadow slot table
  logic [mstt_pkg::OWNER_W-1:0] tbl_owner [mstt_pkg::SLOTS];
  logic [mstt_pkg::ID_W-1:0]    tbl_id    [mstt_pkg::SLOTS];
  logic                         tbl_en    [mstt_pkg::SLOTS];
  logic [mstt_pkg::TIME_W-1:0]  tbl_ival  [mstt_pkg::SLOTS];
  logic [mstt_pkg::TIME_W-1:0]  tbl_rem   [mstt_pkg::SLOTS];

  mstt_pkg::out_item_t owed_q [$];

  initial begin
    mismatches   = 0;
    results_owed = 0;
  end

  task automatic clear_slot(input int i);
    tbl_owner[i] = '0;
    tbl_id[i]    = '0;
    tbl_en[i]    = 1'b0;
    tbl_ival[i]  = '0;
    tbl_rem[i]   = '0;
  endtask

  // first non-reserved occupied slot with this id; owner 0 matches any
  function automatic int find_timer(input logic [mstt_pkg::OWNER_W-1:0] who,
                                    input logic [mstt_pkg::ID_W-1:0] id);
    if (id == '0) return -1;
    for (int i = mstt_pkg::RESERVED_SLOTS; i < mstt_pkg::SLOTS; i++) begin
      if (tbl_id[i] == id && (who == '0 || tbl_owner[i] == who)) return i;
    end
    return -1;
  endfunction

  function automatic logic [mstt_pkg::TIME_W-1:0] earliest_due();
    logic [mstt_pkg::TIME_W-1:0] best;
    best = '0;
    for (int i = 0; i < mstt_pkg::SLOTS; i++) begin
      if (tbl_id[i] != '0 && tbl_en[i] && (best == '0 || tbl_rem[i] < best))
        best = tbl_rem[i];
    end
    return best;
  endfunction

  // apply one operation to the shadow table, queue the results it owes
  task automatic apply_timer_op(input mstt_pkg::in_item_t op);
    mstt_pkg::out_item_t         r;
    mstt_pkg::out_item_t         batch [$];
    int                          s;
    int                          fired_n;
    bit                          any;
    logic [mstt_pkg::TIME_W-1:0] due;
    r       = '0;
    fired_n = 0;
    any     = 1'b0;
    r.status = mstt_pkg::ST_OK;
    case (op.operation)
      mstt_pkg::OP_TICK: begin
        for (int i = 0; i < mstt_pkg::SLOTS; i++) begin
          if (tbl_id[i] == '0 || !tbl_en[i]) continue;
          if (op.elapsed >= tbl_rem[i]) begin
            tbl_rem[i] = tbl_ival[i];
            if (fired_n < mstt_pkg::MAX_RESULTS) begin
              r                = '0;
              r.status         = mstt_pkg::ST_OK;
              r.slot_index     = mstt_pkg::SLOT_W'(i);
              r.fired          = 1'b1;
              r.fired_owner    = tbl_owner[i];
              r.fired_timer_id = tbl_id[i];
              batch.push_back(r);
              fired_n++;
            end
          end else begin
            tbl_rem[i] = tbl_rem[i] - op.elapsed;
          end
        end
        // idle tick
        if (batch.size() == 0) begin
          r = '0;
          r.status = mstt_pkg::ST_OK;
          batch.push_back(r);
        end
      end
      mstt_pkg::OP_SET: begin
        if (op.timer_id == '0 || op.period == '0) begin
          r.status = mstt_pkg::ST_INVALID;
        end else begin
          s = find_timer(op.owner, op.timer_id);
          if (s >= 0) clear_slot(s);
          s = -1;
          for (int i = mstt_pkg::RESERVED_SLOTS; i < mstt_pkg::SLOTS; i++) begin
            if (s < 0 && tbl_id[i] == '0) s = i;
          end
          if (s < 0) begin
            r.status = mstt_pkg::ST_NO_SLOT;
          end else begin
            tbl_owner[s] = op.owner;
            tbl_id[s]    = op.timer_id;
            tbl_en[s]    = 1'b1;
            tbl_ival[s]  = op.period;
            tbl_rem[s]   = op.period;
            r.slot_index = mstt_pkg::SLOT_W'(s);
          end
        end
        batch.push_back(r);
      end
      mstt_pkg::OP_KILL: begin
        s = find_timer(op.owner, op.timer_id);
        if (s < 0) begin
          r.status = mstt_pkg::ST_NOT_FOUND;
        end else begin
          clear_slot(s);
          r.slot_index = mstt_pkg::SLOT_W'(s);
        end
        batch.push_back(r);
      end
      mstt_pkg::OP_KILL_ALL: begin
        for (int i = 0; i < mstt_pkg::SLOTS; i++) begin
          if (tbl_id[i] != '0 && tbl_owner[i] == op.owner) begin
            clear_slot(i);
            any = 1'b1;
          end
        end
        r.status = any ? mstt_pkg::ST_OK : mstt_pkg::ST_NOT_FOUND;
        batch.push_back(r);
      end
      mstt_pkg::OP_ENABLE, mstt_pkg::OP_DISABLE: begin
        s = find_timer('0, op.timer_id);
        if (s < 0) begin
          r.status = mstt_pkg::ST_NOT_FOUND;
        end else begin
          tbl_en[s]    = (op.operation == mstt_pkg::OP_ENABLE);
          r.slot_index = mstt_pkg::SLOT_W'(s);
        end
        batch.push_back(r);
      end
      default: begin
        r.status = mstt_pkg::ST_INVALID;
        batch.push_back(r);
      end
    endcase
    due = earliest_due();
    foreach (batch[k]) begin
      batch[k].next_due = due;
      batch[k].last     = (k == batch.size() - 1);
      owed_q.push_back(batch[k]);
    end
  endtask

  task automatic report_bad(input string why, input mstt_pkg::out_item_t exp_r,
                            input mstt_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s", $realtime, why);
      $display("  exp: st=%0d slot=%0d fired=%0b own=%h id=%h due=%0d last=%0b",
               exp_r.status, exp_r.slot_index, exp_r.fired, exp_r.fired_owner,
               exp_r.fired_timer_id, exp_r.next_due, exp_r.last);
      $display("  got: st=%0d slot=%0d fired=%0b own=%h id=%h due=%0d last=%0b",
               got.status, got.slot_index, got.fired, got.fired_owner,
               got.fired_timer_id, got.next_due, got.last);
    end
  endtask

  always @(posedge clk) begin
    mstt_pkg::out_item_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < mstt_pkg::SLOTS; i++) clear_slot(i);
      owed_q.delete();
    end else begin
      if (in_valid && in_ready) apply_timer_op(in_data);
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          report_bad("result transfer with nothing expected", '0, out_data);
        end else begin
          exp_r = owed_q.pop_front();
          if (out_data.status         !== exp_r.status     ||
              out_data.slot_index     !== exp_r.slot_index ||
              out_data.fired          !== exp_r.fired      ||
              out_data.fired_owner    !== exp_r.fired_owner ||
              out_data.fired_timer_id !== exp_r.fired_timer_id ||
              out_data.next_due       !== exp_r.next_due   ||
              out_data.last           !== exp_r.last)
            report_bad("result mismatch", exp_r, out_data);
        end
      end
    end
    results_owed = owed_q.size();
  end

endmodule

// File: sim/multi_slot_periodic_timer_table_tb.sv
`timescale 1ns / 1ps

module multi_slot_periodic_timer_table_tb;

  localparam int RANDOM_ITEMS = 100;
  localparam int HOLD_CYCLES  = 300;  // long receiver stall
  localparam int DRAIN_CYCLES = 80;   // > an operation's walks plus a fired walk

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  mstt_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  mstt_pkg::out_item_t out_data;

  int mismatches;
  int results_owed;

  // idling switches per side, and the request for one long receiver stall
  bit in_idle_en;
  bit out_idle_en;
  bit hold_req;

  multi_slot_periodic_timer_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // predicts every result and compares; hands back counts only
  mstt_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit: the slowest legal run is roughly 170 operations, each with its
  // table walks plus up to 16 fired results with receiver hold-offs, plus one
  // long receiver stall; the time limit below sits well above that.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic mstt_pkg::in_item_t op_item(
      input logic [mstt_pkg::OP_W-1:0]    op,
      input logic [mstt_pkg::OWNER_W-1:0] who,
      input logic [mstt_pkg::ID_W-1:0]    id,
      input logic [mstt_pkg::TIME_W-1:0]  per,
      input logic [mstt_pkg::TIME_W-1:0]  ela);
    mstt_pkg::in_item_t it;
    it.operation = op;
    it.owner     = who;
    it.timer_id  = id;
    it.period    = per;
    it.elapsed   = ela;
    return it;
  endfunction

  // small owner/id pools so that set, kill and enable actually hit slots
  function automatic logic [mstt_pkg::OWNER_W-1:0] pick_owner();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'h00A5;
      3:       return 16'hBEEF;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [mstt_pkg::ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return '0;
    if (r == 11) return 15'h7FFF;
    return mstt_pkg::ID_W'(r);
  endfunction

  // Mostly well-formed operations on the shared pools with short periods
  // so ticks fire often; about one in ten is raw noise over all bits,
  // including the two undefined operation codes.
  function automatic mstt_pkg::in_item_t draw_timer_op();
    mstt_pkg::in_item_t it;
    int                 pick;
    if ($urandom_range(0, 9) == 0) begin
      it.operation = mstt_pkg::OP_W'($urandom);
      it.owner     = mstt_pkg::OWNER_W'($urandom);
      it.timer_id  = mstt_pkg::ID_W'($urandom);
      it.period    = mstt_pkg::TIME_W'($urandom);
      it.elapsed   = mstt_pkg::TIME_W'($urandom);
      return it;
    end
    pick = $urandom_range(0, 99);
    if (pick < 35)      it.operation = mstt_pkg::OP_TICK;
    else if (pick < 65) it.operation = mstt_pkg::OP_SET;
    else if (pick < 75) it.operation = mstt_pkg::OP_KILL;
    else if (pick < 80) it.operation = mstt_pkg::OP_KILL_ALL;
    else if (pick < 90) it.operation = mstt_pkg::OP_ENABLE;
    else                it.operation = mstt_pkg::OP_DISABLE;
    it.owner    = pick_owner();
    it.timer_id = pick_id();
    it.period   = ($urandom_range(0, 9) == 0) ? mstt_pkg::TIME_W'($urandom)
                                              : mstt_pkg::TIME_W'($urandom_range(1, 40));
    it.elapsed  = ($urandom_range(0, 9) == 0) ? mstt_pkg::TIME_W'($urandom)
                                              : mstt_pkg::TIME_W'($urandom_range(0, 25));
    return it;
  endfunction

  // One input transfer. Drives at the falling edge; valid is only dropped
  // when an idle gap is drawn, so back-to-back items keep valid high.
  task automatic send_op(input mstt_pkg::in_item_t it);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted result has been transferred.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // Fill the table with fresh ids past capacity (the last sets see no free
  // slot), tick far enough to fire every enabled slot, then clear them again.
  task automatic fill_and_fire();
    logic [mstt_pkg::OWNER_W-1:0] who;
    who = 16'h0042;
    for (int k = 0; k < mstt_pkg::SLOTS + 1; k++)
      send_op(op_item(mstt_pkg::OP_SET, who, mstt_pkg::ID_W'(100 + k),
                      mstt_pkg::TIME_W'($urandom_range(1, 40)), '0));
    send_op(op_item(mstt_pkg::OP_TICK, '0, '0, '0, 24'hFFFFFF));
    send_op(op_item(mstt_pkg::OP_KILL_ALL, who, '0, '0, '0));
  endtask

  // Receiver: per result a random hold-off when idling is on, plus one long stall
  // on request while the sender keeps offering items.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = out_idle_en ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    in_valid    = 1'b0;
    in_data     = '0;
    rst_n       = 1'b0;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    hold_req    = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // ---- directed ----
    // idle tick, empty table
    send_op(op_item(mstt_pkg::OP_TICK, '0, '0, '0, '0));
    // id zero rejected, period zero rejected
    send_op(op_item(mstt_pkg::OP_SET, 16'h0001, '0, 24'd5, '0));
    send_op(op_item(mstt_pkg::OP_SET, 16'h0001, 15'd1, '0, '0));
    // all-ones fields
    send_op(op_item(mstt_pkg::OP_SET, 16'hFFFF, 15'h7FFF, 24'hFFFFFF, '0));
    send_op(op_item(mstt_pkg::OP_SET, 16'h0001, 15'd1, 24'd3, '0));
    // same owner+id: replace
    send_op(op_item(mstt_pkg::OP_SET, 16'h0001, 15'd1, 24'd7, '0));
    // same id, other owner
    send_op(op_item(mstt_pkg::OP_SET, 16'h0002, 15'd1, 24'd4, '0));
    // kill and enable with id zero
    send_op(op_item(mstt_pkg::OP_KILL, '0, '0, '0, '0));
    send_op(op_item(mstt_pkg::OP_ENABLE, '0, '0, '0, '0));
    // match by id alone
    send_op(op_item(mstt_pkg::OP_DISABLE, '0, 15'd1, '0, '0));
    // fires exactly at zero
    send_op(op_item(mstt_pkg::OP_TICK, '0, '0, '0, 24'd4));
    send_op(op_item(mstt_pkg::OP_ENABLE, 16'h1234, 15'd1, '0, '0));
    // everything fires
    send_op(op_item(mstt_pkg::OP_TICK, '0, '0, '0, 24'hFFFFFF));
    // any owner, first match; then owner mismatch
    send_op(op_item(mstt_pkg::OP_KILL, '0, 15'd1, '0, '0));
    send_op(op_item(mstt_pkg::OP_KILL, 16'h0003, 15'd1, '0, '0));
    send_op(op_item(mstt_pkg::OP_KILL_ALL, 16'h0002, '0, '0, '0));
    // nothing left
    send_op(op_item(mstt_pkg::OP_KILL_ALL, 16'h0002, '0, '0, '0));
    // undefined codes
    send_op(op_item(3'd6, 16'hFFFF, 15'h7FFF, 24'hFFFFFF, 24'hFFFFFF));
    send_op(op_item(3'd7, '0, '0, '0, '0));
    // owner-0 slot, then kill_all clears owner-0 slots
    send_op(op_item(mstt_pkg::OP_SET, '0, 15'd9, 24'd2, '0));
    send_op(op_item(mstt_pkg::OP_KILL_ALL, '0, '0, '0, '0));
    send_op(op_item(mstt_pkg::OP_DISABLE, '0, 15'h7FFF, '0, '0));
    // disabled slot holds
    send_op(op_item(mstt_pkg::OP_TICK, '0, '0, '0, 24'd1));
    send_op(op_item(mstt_pkg::OP_KILL_ALL, 16'hFFFF, '0, '0, '0));
    drain_results();

    // ---- random ----
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // idling mix changes every 30 items; the first stretch runs flat out
      if (n % 30 == 0) begin
        case (n / 30)
          0:       begin in_idle_en = 1'b0; out_idle_en = 1'b0; end
          2:       begin in_idle_en = 1'b1; out_idle_en = 1'b0; end
          3:       begin in_idle_en = 1'b0; out_idle_en = 1'b1; end
          default: begin in_idle_en = 1'b1; out_idle_en = 1'b1; end
        endcase
      end
      if (n == 20 || n == 70) fill_and_fire();
      if (n == 45) hold_req = 1'b1;   // block fills and backs up the input
      if (n == 90) drain_results();   // sender pause until all results are in
      send_op(draw_timer_op());
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
